// File: rtl/resampling_wheel_selector_macros.svh
// ----------------------------------------------------------------------------
// Resampling wheel selector assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef RESAMPLING_WHEEL_SELECTOR_MACROS_SVH
`define RESAMPLING_WHEEL_SELECTOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rws check failed");

// Consequent must hold in the cycle after the antecedent.
`define RWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rws check failed");

`endif

// File: rtl/rws_pkg.sv
// ----------------------------------------------------------------------------
// Resampling wheel selector package
// Widths, action codes, sequencer states and the weight RAM request type.
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int WEIGHT_BITS   = 16;
    localparam int RF_BITS       = 16;
    localparam int SLOT_BITS     = $clog2(MAX_PARTICLES);
    localparam int COUNT_BITS    = SLOT_BITS + 1;
    localparam int STEP_BITS     = COUNT_BITS + 1;
    localparam int BETA_BITS     = WEIGHT_BITS + 2;
    localparam int ACTION_BITS   = 2;
    localparam int PROD_BITS     = RF_BITS + WEIGHT_BITS;
    localparam int INC_BITS      = WEIGHT_BITS + 1;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(MAX_PARTICLES);

    localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_BEGIN = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_DRAW  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADD  = 4'b0010,
        S_READ = 4'b0100,
        S_CMP  = 4'b1000
    } state_t;

    typedef struct packed {
        logic                   we;
        logic [SLOT_BITS-1:0]   addr;
        logic [WEIGHT_BITS-1:0] wdata;
    } ram_req_t;

endpackage

// File: rtl/rws_cmd_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one load, begin or draw word.
// ----------------------------------------------------------------------------
interface rws_cmd_if import rws_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [ACTION_BITS-1:0] action;
    logic [SLOT_BITS-1:0]   slot;
    logic [WEIGHT_BITS-1:0] weight;
    logic [RF_BITS-1:0]     random_fraction;

    modport source (output valid, action, slot, weight, random_fraction, input ready);
    modport sink   (input valid, action, slot, weight, random_fraction, output ready);
endinterface

// File: rtl/rws_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one chosen slot word per draw.
// ----------------------------------------------------------------------------
interface rws_result_if import rws_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [SLOT_BITS-1:0] chosen_slot;
    logic                 walk_limit_hit;

    modport source (output valid, chosen_slot, walk_limit_hit, input ready);
    modport sink   (input valid, chosen_slot, walk_limit_hit, output ready);
endinterface

// File: rtl/resampling_wheel_selector.sv
// ----------------------------------------------------------------------------
// Resampling wheel selector
// Particle filter resampling wheel: weight store, running max and wheel walk.
// ----------------------------------------------------------------------------
// Usage:
//   cmd    : valid/ready words. action load writes weight into slot (slot 0
//            restarts the running max), begin places the wheel at
//            floor(r * count) and clears beta, draw picks one slot.
//   result : one word per draw: chosen_slot and walk_limit_hit.
//   cfg_we / cfg_wdata : particle count, which the user writes only while idle;
//            the block does not enforce it (0 acts as 1, above 1024 as 1024).
// Timing:
//   Load, begin and unused actions finish in the accept cycle; ready stays
//   high, so these words go back to back. A draw's result word becomes valid
//   after S_ADD and one S_READ/S_CMP pair for each weight the wheel walks
//   past (at most 2 * count) plus a final pair; ready returns with it, so a
//   draw is not accepted until the previous draw's result is out. Each step
//   is one read of the single-port weight RAM plus one compare/subtract;
//   the walk is the rate limiter.
// Reset: the sequencer idles, running max, wheel position and beta clear,
//   count goes to 1024. Weights are undefined until loaded.
// Stall: a finished draw sits in the output register; a following draw
//   waits at its last compare until that word is taken.
// ----------------------------------------------------------------------------
`include "resampling_wheel_selector_macros.svh"

module resampling_wheel_selector import rws_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    rws_cmd_if.sink               cmd,
    rws_result_if.source          result
);

    // architectural state
    state_t                 state_reg, state_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [WEIGHT_BITS-1:0] max_reg, max_next;
    logic [SLOT_BITS-1:0]   pos_reg, pos_next;
    logic [BETA_BITS-1:0]   beta_reg, beta_next;

    // walk datapath
    logic [PROD_BITS-1:0]   prod_reg, prod_next;
    logic [STEP_BITS-1:0]   steps_reg, steps_next;

    // output word register
    logic                   out_valid_reg, out_valid_next;
    logic [SLOT_BITS-1:0]   out_slot_reg, out_slot_next;
    logic                   out_hit_reg, out_hit_next;

    ram_req_t               ram_req;
    logic [WEIGHT_BITS-1:0] ram_rdata;

    logic [COUNT_BITS-1:0]  live_n;
    logic [STEP_BITS-1:0]   guard;
    logic                   accept;
    logic                   out_free;
    logic [COUNT_BITS+RF_BITS-1:0] begin_prod;
    logic [INC_BITS-1:0]    inc;
    logic [BETA_BITS:0]     beta_sum;
    logic [COUNT_BITS-1:0]  pos_plus;
    logic                   beta_gt_w;
    logic                   guard_hit;

    rws_weight_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // effective count, clamped to 1..MAX_PARTICLES
    always_comb
    begin
        priority if (count_reg == '0)
            live_n = COUNT_BITS'(1);
        else if (count_reg > COUNT_RESET)
            live_n = COUNT_RESET;
        else
            live_n = count_reg;
    end

    assign guard      = {live_n, 1'b0};
    assign accept     = cmd.valid && cmd.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign begin_prod = (COUNT_BITS+RF_BITS)'(live_n)
                      * (COUNT_BITS+RF_BITS)'(cmd.random_fraction);
    // (2 * r * max) >> 16 == (r * max) >> 15
    assign inc        = prod_reg[PROD_BITS-1:RF_BITS-1];
    assign beta_sum   = {1'b0, beta_reg} + (BETA_BITS+1)'(inc);
    assign pos_plus   = {1'b0, pos_reg} + COUNT_BITS'(1);
    assign beta_gt_w  = beta_reg > BETA_BITS'(ram_rdata);
    assign guard_hit  = steps_reg >= guard;

    // RAM port: load writes while idle, otherwise read under the wheel
    always_comb
    begin
        ram_req.we    = accept && (cmd.action == ACT_LOAD);
        ram_req.addr  = ram_req.we ? cmd.slot : pos_reg;
        ram_req.wdata = cmd.weight;
    end

    always_comb
    begin
        state_next     = state_reg;
        max_next       = max_reg;
        pos_next       = pos_reg;
        beta_next      = beta_reg;
        prod_next      = prod_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_slot_next  = out_slot_reg;
        out_hit_next   = out_hit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.action == ACT_LOAD)
                    begin
                        if (cmd.slot == '0 || cmd.weight > max_reg)
                            max_next = cmd.weight;
                    end
                    else if (cmd.action == ACT_BEGIN)
                    begin
                        pos_next  = begin_prod[RF_BITS +: SLOT_BITS];
                        beta_next = '0;
                    end
                    else if (cmd.action == ACT_DRAW)
                    begin
                        prod_next  = PROD_BITS'(cmd.random_fraction) * PROD_BITS'(max_reg);
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ADD:
            begin
                // saturating beta add, stale position restarts at slot 0
                beta_next  = beta_sum[BETA_BITS] ? '1 : beta_sum[BETA_BITS-1:0];
                if ({1'b0, pos_reg} >= live_n)
                    pos_next = '0;
                steps_next = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (beta_gt_w && !guard_hit)
                begin
                    beta_next  = beta_reg - BETA_BITS'(ram_rdata);
                    pos_next   = (pos_plus >= live_n) ? '0 : pos_plus[SLOT_BITS-1:0];
                    steps_next = steps_reg + STEP_BITS'(1);
                    state_next = S_READ;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next  = pos_reg;
                    out_hit_next   = beta_gt_w;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= COUNT_RESET;
            max_reg       <= '0;
            pos_reg       <= '0;
            beta_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                count_reg <= cfg_wdata;
            max_reg       <= max_next;
            pos_reg       <= pos_next;
            beta_reg      <= beta_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        steps_reg    <= steps_next;
        out_slot_reg <= out_slot_next;
        out_hit_reg  <= out_hit_next;
    end

    assign cmd.ready             = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.chosen_slot    = out_slot_reg;
    assign result.walk_limit_hit = out_hit_reg;

    // wheel address always inside the live count while walking
    `RWS_ASSERT_NOW(a_pos_in_range, state_reg == S_READ, ({1'b0, pos_reg} < live_n))
    // step count never passes the two-lap guard
    `RWS_ASSERT_NOW(a_steps_bounded, state_reg == S_CMP, steps_reg <= guard)
    // a step never raises beta (a zero weight leaves it unchanged)
    `RWS_ASSERT_NEXT(a_beta_drops, state_reg == S_CMP && state_next == S_READ,
                     beta_reg <= $past(beta_reg))
    // a draw goes straight into the beta update
    `RWS_ASSERT_NEXT(a_draw_starts, accept && cmd.action == ACT_DRAW, state_reg == S_ADD)

endmodule

// File: rtl/rws_weight_ram.sv
// ----------------------------------------------------------------------------
// Weight RAM
// Single-port weight store, one registered read per cycle plus a write when we is set.
// ----------------------------------------------------------------------------
module rws_weight_ram import rws_pkg::*; (
    input  logic                   clk,
    input  ram_req_t               req,
    output logic [WEIGHT_BITS-1:0] rdata
);

    logic [WEIGHT_BITS-1:0] mem [MAX_PARTICLES];
    logic [WEIGHT_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        rdata_reg <= mem[req.addr];
    end

    assign rdata = rdata_reg;

endmodule
